// File: src/lmpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpp_pkg
// Shared types, codes and helpers for the LED matrix pixel packer.
// ----------------------------------------------------------------------------
package lmpp_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 128;
  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned GAMMA_DEPTH = 256;
  localparam int unsigned GIDX_W      = $clog2(GAMMA_DEPTH);
  localparam int unsigned ADDR_W      = 15;
  localparam int unsigned WORD_W      = 3 * LEVEL_W;
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 2;

  // opcodes
  localparam logic OP_PIXEL      = 1'b0;
  localparam logic OP_GAMMA_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ORDER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_CANVAS  = 2'd3;

  // color orders
  localparam logic [2:0] ORDER_RGB = 3'd0;
  localparam logic [2:0] ORDER_RBG = 3'd1;
  localparam logic [2:0] ORDER_GRB = 3'd2;
  localparam logic [2:0] ORDER_GBR = 3'd3;
  localparam logic [2:0] ORDER_BRG = 3'd4;
  localparam logic [2:0] ORDER_BGR = 3'd5;

  localparam logic [8:0] RST_PANEL_WIDTH  = 9'd64;
  localparam logic [7:0] RST_PANEL_HEIGHT = 8'd32;

  typedef struct packed {
    logic       opcode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] gamma_index;
    logic [9:0] gamma_value;
  } pixel_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] buffer_word;
  } pixel_out_t;

  // one queued operation between front and back
  typedef struct packed {
    logic               is_load;
    logic [ADDR_W-1:0]  word_address;
    logic [GIDX_W-1:0]  red;
    logic [GIDX_W-1:0]  green;
    logic [GIDX_W-1:0]  blue;
    logic [GIDX_W-1:0]  gamma_index;
    logic [LEVEL_W-1:0] gamma_value;
  } op_entry_t;

  function automatic logic [WORD_W-1:0] pack_levels(
    input logic [2:0]         order,
    input logic [LEVEL_W-1:0] lr,
    input logic [LEVEL_W-1:0] lg,
    input logic [LEVEL_W-1:0] lb
  );
    logic [WORD_W-1:0] w;
    case (order)
      ORDER_RGB: w = {lb, lg, lr};
      ORDER_RBG: w = {lg, lb, lr};
      ORDER_GRB: w = {lr, lb, lg};
      ORDER_GBR: w = {lg, lr, lb};
      ORDER_BRG: w = {lb, lr, lg};
      ORDER_BGR: w = {lr, lg, lb};
      default:   w = {lb, lg, lr};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: src/lmpp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpp_front
// Holds the configuration, accepts items, drops off-panel pixels and
// computes the interleaved frame-store address.
// ----------------------------------------------------------------------------
module lmpp_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lmpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmpp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire lmpp_pkg::pixel_in_t          in_data,
  input  wire logic                         queue_full,
  output logic                              push,
  output lmpp_pkg::op_entry_t               push_entry,
  output logic [2:0]                        rgb_order
);

  logic [8:0] panel_width;
  logic [7:0] panel_height;
  logic       fold_canvas;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= lmpp_pkg::RST_PANEL_WIDTH;
      panel_height <= lmpp_pkg::RST_PANEL_HEIGHT;
      rgb_order    <= lmpp_pkg::ORDER_RGB;
      fold_canvas  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmpp_pkg::CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        lmpp_pkg::CFG_PANEL_HEIGHT: panel_height <= cfg_data[7:0];
        lmpp_pkg::CFG_COLOR_ORDER:  rgb_order    <= cfg_data[2:0];
        lmpp_pkg::CFG_FOLD_CANVAS:  fold_canvas  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [8:0]  w;
  logic [7:0]  h;
  logic [7:0]  hw;
  logic [6:0]  half;
  logic [8:0]  col;
  logic [7:0]  row;
  logic [7:0]  row_in_half;
  logic        bottom;
  logic        on_panel;
  logic [16:0] prod;
  logic [17:0] lin;
  logic        accept;

  always_comb begin
    w    = (panel_width > 9'(lmpp_pkg::MAX_WIDTH)) ? 9'(lmpp_pkg::MAX_WIDTH) : panel_width;
    h    = (panel_height > 8'(lmpp_pkg::MAX_HEIGHT)) ? 8'(lmpp_pkg::MAX_HEIGHT)
                                                     : panel_height;
    hw   = w[8:1];
    half = h[7:1];
    col  = {1'b0, in_data.x};
    row  = in_data.y;
    if (fold_canvas) begin
      on_panel = (in_data.x < hw) && ({1'b0, in_data.y} < {h, 1'b0});
      if (in_data.y >= h) begin
        row = in_data.y - h;
        col = hw[0] ? ({1'b0, hw} - {1'b0, in_data.x}) : ({1'b0, hw} + {1'b0, in_data.x});
      end
    end else begin
      on_panel = ({1'b0, in_data.x} < w) && (in_data.y < h);
    end
    bottom      = (row >= {1'b0, half});
    row_in_half = bottom ? (row - {1'b0, half}) : row;
    prod        = row_in_half * w;
    lin         = {1'b0, prod} + {9'd0, col};
  end

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && ((in_data.opcode == lmpp_pkg::OP_GAMMA_LOAD) || on_panel);

  always_comb begin
    push_entry.is_load      = (in_data.opcode == lmpp_pkg::OP_GAMMA_LOAD);
    push_entry.word_address = {lin[13:0], bottom};
    push_entry.red          = in_data.red;
    push_entry.green        = in_data.green;
    push_entry.blue         = in_data.blue;
    push_entry.gamma_index  = in_data.gamma_index;
    push_entry.gamma_value  = in_data.gamma_value;
  end

endmodule
`default_nettype wire

// File: src/lmpp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpp_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module lmpp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lmpp_pkg::op_entry_t push_entry,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output lmpp_pkg::op_entry_t      head
);

  lmpp_pkg::op_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/lmpp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmpp_back
// Gamma table loads and lookups, color packing and the output register.
// ----------------------------------------------------------------------------
module lmpp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                not_empty,
  input  wire lmpp_pkg::op_entry_t head,
  output logic                     pop,
  input  wire logic [2:0]          rgb_order,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lmpp_pkg::pixel_out_t     out_data
);

  // one table copy per color so all three lookups happen in the same cycle
  logic [lmpp_pkg::LEVEL_W-1:0] gamma_r [lmpp_pkg::GAMMA_DEPTH];
  logic [lmpp_pkg::LEVEL_W-1:0] gamma_g [lmpp_pkg::GAMMA_DEPTH];
  logic [lmpp_pkg::LEVEL_W-1:0] gamma_b [lmpp_pkg::GAMMA_DEPTH];

  logic                         s1_valid;
  logic [lmpp_pkg::ADDR_W-1:0]  s1_addr;
  logic [lmpp_pkg::LEVEL_W-1:0] lvl_r;
  logic [lmpp_pkg::LEVEL_W-1:0] lvl_g;
  logic [lmpp_pkg::LEVEL_W-1:0] lvl_b;
  logic                         s1_move;
  logic                         do_load;
  logic                         do_read;

  assign s1_move = s1_valid && (!out_valid || !out_stall);
  assign pop     = not_empty && (!s1_valid || s1_move);
  assign do_load = pop && head.is_load;
  assign do_read = pop && !head.is_load;

  always_ff @(posedge clk) begin
    if (do_load) begin
      gamma_r[head.gamma_index] <= head.gamma_value;
      gamma_g[head.gamma_index] <= head.gamma_value;
      gamma_b[head.gamma_index] <= head.gamma_value;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      lvl_r   <= gamma_r[head.red];
      lvl_g   <= gamma_g[head.green];
      lvl_b   <= gamma_b[head.blue];
      s1_addr <= head.word_address;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.word_address <= s1_addr;
      out_data.buffer_word  <= lmpp_pkg::pack_levels(rgb_order, lvl_r, lvl_g, lvl_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= !head.is_load;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/led_matrix_pixel_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_pixel_packer
// Pixel writes become interleaved frame-store addresses and gamma-corrected
// 30-bit words; gamma loads fill the lookup table.
// ----------------------------------------------------------------------------
// One item is taken per clock while in_stall is low. The front computes the
// address (one 8x9 multiply and add) and drops off-panel pixels; a two-entry
// queue feeds the back, which reads three gamma table copies in the same
// cycle and packs the levels into the output register. A pixel result passes
// the queue, level registers and output register; gamma loads and dropped
// pixels give none. Gamma entries must be loaded before a pixel uses them.
module led_matrix_pixel_packer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lmpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lmpp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lmpp_pkg::pixel_in_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lmpp_pkg::pixel_out_t                 out_data
);

  logic                queue_full;
  logic                push;
  lmpp_pkg::op_entry_t push_entry;
  logic                pop;
  logic                not_empty;
  lmpp_pkg::op_entry_t head;
  logic [2:0]          rgb_order;

  lmpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry),
    .rgb_order  (rgb_order)
  );

  lmpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  lmpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .rgb_order  (rgb_order),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: dv/led_matrix_pixel_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_pixel_packer_tb
// Self-checking bench for the LED matrix pixel packer. Pixel writes and
// gamma loads go in through the valid/stall input channel. A shadow copy of
// the gamma table and the panel registers gives the expected frame-store
// address and packed word for each on-panel pixel. The bench covers
// directed corners, fold mapping, extreme register settings and random
// traffic under several idle patterns, plus a long output hold-off.
// ----------------------------------------------------------------------------
module led_matrix_pixel_packer_tb;
  import lmpp_pkg::*;

  localparam logic [2:0] ORDER_SPARE6 = 3'd6;
  localparam logic [2:0] ORDER_SPARE7 = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 200;
  localparam int MAX_REPORTS   = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  pixel_in_t             in_data;
  logic                  out_valid;
  logic                  out_stall;
  pixel_out_t            out_data;

  logic [8:0]         width_q;
  logic [7:0]         height_q;
  logic [2:0]         order_q;
  logic               fold_q;
  logic [LEVEL_W-1:0] gamma_q [GAMMA_DEPTH];
  bit                 gamma_loaded [GAMMA_DEPTH];
  logic [7:0]         loaded_idx [$];
  pixel_out_t         pending_words [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int error_count = 0;
  int stall_cycles = 0;
  pixel_out_t want;
  pixel_out_t got;

  led_matrix_pixel_packer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned panel_w();
    return (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
  endfunction

  function automatic int unsigned panel_h();
    return (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
  endfunction

  // interleaved frame-store address; 0 when the pixel is off the panel
  function automatic bit map_to_panel(input logic [7:0] px, input logic [7:0] py,
                                      output logic [ADDR_W-1:0] addr);
    int unsigned w, h, hw, col, row, bottom, lin;
    addr = '0;
    w = panel_w();
    h = panel_h();
    if (fold_q) begin
      hw = w / 2;
      if (px >= hw || py >= 2 * h) return 1'b0;
      col = px;
      row = py;
      if (row >= h) begin
        row = row - h;
        col = (hw % 2 == 1) ? hw - px : hw + px;
      end
    end else begin
      if (px >= w || py >= h) return 1'b0;
      col = px;
      row = py;
    end
    bottom = 0;
    if (row >= h / 2) begin
      row = row - h / 2;
      bottom = 1;
    end
    lin = (row * w + col) * 2 + bottom;
    addr = lin[ADDR_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] gamma_word(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
    int unsigned sr, sg, sb;
    logic [WORD_W-1:0] lr, lg, lb;
    case (order_q)
      ORDER_RBG: begin sr = 0;  sg = 20; sb = 10; end
      ORDER_GRB: begin sr = 20; sg = 0;  sb = 10; end
      ORDER_GBR: begin sr = 10; sg = 20; sb = 0;  end
      ORDER_BRG: begin sr = 10; sg = 0;  sb = 20; end
      ORDER_BGR: begin sr = 20; sg = 10; sb = 0;  end
      default:   begin sr = 0;  sg = 10; sb = 20; end
    endcase
    lr = gamma_q[r];
    lg = gamma_q[g];
    lb = gamma_q[b];
    return (lr << sr) | (lg << sg) | (lb << sb);
  endfunction

  function automatic void account_transfer(input pixel_in_t item);
    logic [ADDR_W-1:0] addr;
    pixel_out_t res;
    if (item.opcode == OP_GAMMA_LOAD) begin
      gamma_q[item.gamma_index] = item.gamma_value;
      if (!gamma_loaded[item.gamma_index]) begin
        gamma_loaded[item.gamma_index] = 1'b1;
        loaded_idx.push_back(item.gamma_index);
      end
    end else if (map_to_panel(item.x, item.y, addr)) begin
      res.word_address = addr;
      res.buffer_word  = gamma_word(item.red, item.green, item.blue);
      pending_words.push_back(res);
    end
  endfunction

  function automatic int unsigned pick_coord(input int unsigned n);
    int unsigned c;
    case ($urandom_range(9))
      0, 1:    c = n - 1;
      2:       c = 0;
      default: c = $urandom_range(n - 1);
    endcase
    return (c > 255) ? 255 : c;
  endfunction

  function automatic logic [7:0] loaded_color(input logic [7:0] c);
    if (gamma_loaded[c]) return c;
    return loaded_idx[$urandom_range(loaded_idx.size() - 1)];
  endfunction

  function automatic pixel_in_t random_item(input int load_pct, input int inside_pct);
    pixel_in_t it;
    int unsigned cw, ch;
    logic [ADDR_W-1:0] addr;
    it.opcode      = ($urandom_range(99) < load_pct) ? OP_GAMMA_LOAD : OP_PIXEL;
    it.x           = 8'($urandom_range(255));
    it.y           = 8'($urandom_range(255));
    it.red         = 8'($urandom_range(255));
    it.green       = 8'($urandom_range(255));
    it.blue        = 8'($urandom_range(255));
    it.gamma_index = 8'($urandom_range(255));
    it.gamma_value = 10'($urandom_range(1023));
    if (it.opcode == OP_PIXEL && $urandom_range(99) < inside_pct) begin
      cw = fold_q ? panel_w() / 2 : panel_w();
      ch = fold_q ? 2 * panel_h() : panel_h();
      if (cw > 0 && ch > 0) begin
        it.x = 8'(pick_coord(cw));
        it.y = 8'(pick_coord(ch));
      end
    end
    // a pixel that lands must only look up entries already loaded
    if (it.opcode == OP_PIXEL && map_to_panel(it.x, it.y, addr)) begin
      it.red   = loaded_color(it.red);
      it.green = loaded_color(it.green);
      it.blue  = loaded_color(it.blue);
    end
    return it;
  endfunction

  function automatic pixel_in_t make_pixel(input logic [7:0] px, input logic [7:0] py,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    pixel_in_t it;
    it.opcode      = OP_PIXEL;
    it.x           = px;
    it.y           = py;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.gamma_index = 8'($urandom_range(255));
    it.gamma_value = 10'($urandom_range(1023));
    return it;
  endfunction

  function automatic pixel_in_t make_load(input logic [7:0] idx, input logic [9:0] level);
    pixel_in_t it;
    it = make_pixel(8'hFF, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
    it.opcode      = OP_GAMMA_LOAD;
    it.gamma_index = idx;
    it.gamma_value = level;
    return it;
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  task automatic send_item(input pixel_in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    account_transfer(item);
  endtask

  task automatic send_random(input int n, input int load_pct, input int inside_pct);
    repeat (n) send_item(random_item(load_pct, inside_pct));
  endtask

  // wait for every outstanding result, then let dropped items clear the pipe
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic set_config(input logic [8:0] w, input logic [7:0] h, input logic [2:0] ord,
                            input logic fold);
    drain_results();
    write_reg(CFG_PANEL_WIDTH, w);
    write_reg(CFG_PANEL_HEIGHT, {1'b0, h});
    write_reg(CFG_COLOR_ORDER, {6'd0, ord});
    write_reg(CFG_FOLD_CANVAS, {8'd0, fold});
    @(negedge clk);
    cfg_we   <= 1'b0;
    width_q  = w;
    height_q = h;
    order_q  = ord;
    fold_q   = fold;
  endtask

  task automatic config_and_run(input logic [8:0] w, input logic [7:0] h,
                                input logic [2:0] ord, input logic fold, input int n);
    set_config(w, h, ord, fold);
    send_random(n, 15, 85);
  endtask

  task automatic test_directed();
    send_item(make_load(8'h00, 10'h2AA));
    send_item(make_load(8'hFF, 10'h3FF));
    send_item(make_load(8'h55, 10'h155));
    send_item(make_load(8'hAA, 10'h000));
    send_item(make_load(8'h01, 10'h001));
    send_item(make_pixel(8'd0, 8'd0, 8'h00, 8'hFF, 8'h55));
    send_item(make_pixel(8'd63, 8'd15, 8'hFF, 8'h00, 8'hAA));
    send_item(make_pixel(8'd0, 8'd16, 8'hAA, 8'h55, 8'h01));
    send_item(make_pixel(8'd63, 8'd31, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_pixel(8'd64, 8'd0, 8'h77, 8'h77, 8'h77));
    send_item(make_pixel(8'd0, 8'd32, 8'h77, 8'h77, 8'h77));
    send_item(make_pixel(8'd255, 8'd255, 8'h77, 8'h77, 8'h77));
    send_item(make_pixel(8'd10, 8'd5, 8'h01, 8'h00, 8'hFF));
  endtask

  task automatic test_fold_mapping();
    set_config(9'd64, 8'd32, ORDER_RGB, 1'b1);
    send_item(make_pixel(8'd0, 8'd0, 8'hFF, 8'h00, 8'h55));
    send_item(make_pixel(8'd31, 8'd15, 8'hAA, 8'hFF, 8'h00));
    send_item(make_pixel(8'd32, 8'd0, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_pixel(8'd0, 8'd32, 8'h55, 8'hAA, 8'h01));
    send_item(make_pixel(8'd31, 8'd63, 8'h00, 8'h01, 8'hFF));
    send_item(make_pixel(8'd0, 8'd64, 8'hFF, 8'hFF, 8'hFF));
    // odd half width mirrors the lower canvas half
    set_config(9'd62, 8'd32, ORDER_BGR, 1'b1);
    send_item(make_pixel(8'd0, 8'd32, 8'hFF, 8'h00, 8'hAA));
    send_item(make_pixel(8'd30, 8'd40, 8'h01, 8'h55, 8'hFF));
    send_item(make_pixel(8'd31, 8'd0, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_register_extremes();
    config_and_run(9'd0, 8'd32, ORDER_RGB, 1'b0, 12);
    config_and_run(9'd64, 8'd0, ORDER_GRB, 1'b0, 12);
    config_and_run(9'd1, 8'd2, ORDER_GBR, 1'b0, 15);
    config_and_run(9'd256, 8'd128, ORDER_BRG, 1'b0, 15);
    config_and_run(9'd511, 8'd255, ORDER_RBG, 1'b0, 15);
    config_and_run(9'd300, 8'd200, ORDER_BGR, 1'b1, 15);
    config_and_run(9'd64, 8'd31, ORDER_RGB, 1'b0, 15);
    config_and_run(9'd16, 8'd3, ORDER_SPARE6, 1'b0, 15);
    config_and_run(9'd256, 8'd128, ORDER_SPARE7, 1'b1, 15);
    config_and_run(9'd1, 8'd128, ORDER_RGB, 1'b1, 10);
    config_and_run(9'd3, 8'd4, ORDER_GRB, 1'b1, 15);
    config_and_run(9'd256, 8'd128, ORDER_RGB, 1'b1, 15);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    logic [8:0] w;
    logic [7:0] h;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      case ($urandom_range(3))
        0:       w = 9'($urandom_range(64, 1));
        1:       w = 9'($urandom_range(256, 65));
        2:       w = 9'd256;
        default: w = 9'($urandom_range(511, 1));
      endcase
      case ($urandom_range(3))
        0:       h = 8'(2 * $urandom_range(64, 1));
        1:       h = 8'($urandom_range(255, 1));
        2:       h = 8'd128;
        default: h = 8'($urandom_range(16, 2));
      endcase
      config_and_run(w, h, 3'($urandom_range(7)), 1'($urandom_range(1)), 30);
    end
  endtask

  task automatic test_random();
    random_phase(8, 87);
    random_phase(87, 8);
    random_phase(0, 0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(9'd64, 8'd32, ORDER_GBR, 1'b0);
    hold_req = HOLD_CYCLES;
    send_random(30, 0, 100);
    drain_results();
    send_random(10, 20, 90);
  endtask

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = out_data;
      if (pending_words.size() == 0) begin
        note_error($sformatf("unexpected result: address %0h word %0h",
                             got.word_address, got.buffer_word));
      end else begin
        want = pending_words.pop_front();
        if (got.word_address !== want.word_address)
          note_error($sformatf("word_address expected %0h got %0h",
                               want.word_address, got.word_address));
        if (got.buffer_word !== want.buffer_word)
          note_error($sformatf("buffer_word expected %0h got %0h",
                               want.buffer_word, got.buffer_word));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    width_q   = RST_PANEL_WIDTH;
    height_q  = RST_PANEL_HEIGHT;
    order_q   = ORDER_RGB;
    fold_q    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fold_mapping();
    test_register_extremes();
    test_random();
    test_backpressure();
    drain_results();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/lmpp_pkg.sv
src/lmpp_front.sv
src/lmpp_queue.sv
src/lmpp_back.sv
src/led_matrix_pixel_packer.sv
dv/led_matrix_pixel_packer_tb.sv
